### rtl/core/sorted_key_quantity_table_defines.svh
// Assertion macros shared by the sorted key/quantity table RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SORTED_KEY_QUANTITY_TABLE_DEFINES_SVH
`define SORTED_KEY_QUANTITY_TABLE_DEFINES_SVH

// Same-cycle implication, reset-qualified
`define SKQT_ASSERT_IMPL(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, reset-qualified
`define SKQT_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/skqt_pkg.sv
// Package for the sorted key/quantity table: sizes, operation and status codes,
// sequencer state type. No dependencies.
`timescale 1ns / 1ps

package skqt_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 31;
	localparam int QTY_W    = 32;
	localparam int ENTRY_W  = KEY_W + QTY_W;

	// Operation codes
	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_LOOKUP = 3'd1;
	localparam logic [2:0] OP_ADJUST = 3'd2;
	localparam logic [2:0] OP_ERASE  = 3'd3;
	localparam logic [2:0] OP_LIST   = 3'd4;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_PRESENT   = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_EXEC,
		S_UP,
		S_UP_LAST,
		S_INS_WR,
		S_DOWN,
		S_DOWN_LAST,
		S_LIST,
		S_RESP
	} state_t;

endpackage

### rtl/core/skqt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module skqt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### rtl/core/sorted_key_quantity_table.sv
// Sorted key/quantity table: sequencer, entry RAM and result register.
// Depends on skqt_pkg, skqt_ram and sorted_key_quantity_table_defines.svh.
`timescale 1ns / 1ps
//
// Usage:
// An item (operation, part_key, quantity_value) transfers when in_valid is
// high and in_stall low. in_stall is high whenever the sequencer is busy, so
// one item is worked on at a time. Results leave on the out channel (status,
// entry_key, entry_quantity, last) through an output register; each transfer
// happens when out_valid is high and out_stall low. last marks the final
// result of an item.
// Steps per item, p = key position:
//   lookup / adjust / absent key: linear key scan, one entry per cycle
//   insert: scan, then entries above p move up one per cycle
//   erase: scan to p, then entries above p move down
//   list: one result per cycle while the receiver does not stall
//   empty list, unknown op, full insert: no scan, straight to the result
// Reset empties the table at once (entry count cleared, no RAM sweep).
// While the receiver stalls, the result register holds and the sequencer
// waits before loading its next result; no result is dropped.
//
`include "sorted_key_quantity_table_defines.svh"

module sorted_key_quantity_table
	import skqt_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [2:0]              operation,
	input  logic [KEY_W-1:0]        part_key,
	input  logic signed [QTY_W-1:0] quantity_value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              status,
	output logic [KEY_W-1:0]        entry_key,
	output logic signed [QTY_W-1:0] entry_quantity,
	output logic                    last
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]   count_q;
	logic               pend_q;
	logic               out_valid_q;

	logic [2:0]         op_q;
	logic [KEY_W-1:0]   key_q;
	logic [QTY_W-1:0]   val_q;
	logic [CNT_W-1:0]   idx_q, prev_q, pos_q;
	logic               hit_q;
	logic [QTY_W-1:0]   held_q;
	logic [1:0]         res_status_q;
	logic [KEY_W-1:0]   res_key_q;
	logic [QTY_W-1:0]   res_qty_q;
	logic [1:0]         status_q;
	logic [KEY_W-1:0]   entry_key_q;
	logic [QTY_W-1:0]   entry_qty_q;
	logic               last_q;

	logic               in_xfer, can_load;
	logic [CNT_W-1:0]   idx_inc;
	logic               scan_done, scan_ge;
	logic [QTY_W-1:0]   adj_sum;

	logic               rd_en, wr_en;
	logic [IDX_W-1:0]   rd_addr, wr_addr;
	logic [ENTRY_W-1:0] wr_data, rd_data;
	logic [KEY_W-1:0]   rd_key;
	logic [QTY_W-1:0]   rd_qty;

	logic               out_load;
	logic [1:0]         ld_status;
	logic [KEY_W-1:0]   ld_key;
	logic [QTY_W-1:0]   ld_qty;
	logic               ld_last;

	// Entry RAM: key in the upper bits, quantity below
	skqt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_entries (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign rd_key = rd_data[ENTRY_W-1:QTY_W];
	assign rd_qty = rd_data[QTY_W-1:0];

	// Handshake helpers
	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign can_load  = !out_valid_q || !out_stall;
	assign idx_inc   = idx_q + 1'b1;
	assign scan_ge   = (rd_key >= key_q);
	assign scan_done = scan_ge || (idx_inc == count_q);
	assign adj_sum   = held_q + val_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					if (operation == OP_LIST) begin
						state_d = (count_q == '0) ? S_RESP : S_LIST;
					end else if (operation > OP_LIST) begin
						state_d = S_RESP;
					end else if (operation == OP_INSERT && count_q >= CNT_W'(CAPACITY)) begin
						state_d = S_RESP;
					end else if (count_q == '0) begin
						state_d = S_EXEC;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (op_q)
					OP_INSERT: begin
						if (hit_q) begin
							state_d = S_RESP;
						end else if (pos_q == count_q) begin
							state_d = S_INS_WR;
						end else begin
							state_d = S_UP;
						end
					end
					OP_ERASE: begin
						if (hit_q && (pos_q + 1'b1 != count_q)) begin
							state_d = S_DOWN;
						end else begin
							state_d = S_RESP;
						end
					end
					default: state_d = S_RESP;
				endcase
			end
			S_UP: begin
				if (idx_q == pos_q) begin
					state_d = S_UP_LAST;
				end
			end
			S_UP_LAST:   state_d = S_INS_WR;
			S_INS_WR:    state_d = S_RESP;
			S_DOWN: begin
				if (idx_inc == count_q) begin
					state_d = S_DOWN_LAST;
				end
			end
			S_DOWN_LAST: state_d = S_RESP;
			S_LIST: begin
				if (can_load && idx_inc == count_q) begin
					state_d = S_IDLE;
				end
			end
			S_RESP: begin
				if (can_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// RAM controls and result loading
	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = idx_q[IDX_W-1:0];
		wr_en     = 1'b0;
		wr_addr   = pos_q[IDX_W-1:0];
		wr_data   = {key_q, val_q};
		out_load  = 1'b0;
		ld_status = res_status_q;
		ld_key    = res_key_q;
		ld_qty    = res_qty_q;
		ld_last   = 1'b1;
		case (state_q)
			S_IDLE: begin
				rd_en   = in_xfer;
				rd_addr = '0;
			end
			S_SCAN: begin
				rd_en   = 1'b1;
				rd_addr = idx_inc[IDX_W-1:0];
			end
			S_EXEC: begin
				wr_en   = (op_q == OP_ADJUST) && hit_q;
				wr_data = {key_q, adj_sum};
			end
			S_UP: begin
				rd_en   = 1'b1;
				wr_en   = pend_q;
				wr_addr = IDX_W'(prev_q + 1'b1);
				wr_data = rd_data;
			end
			S_UP_LAST: begin
				wr_en   = 1'b1;
				wr_addr = IDX_W'(prev_q + 1'b1);
				wr_data = rd_data;
			end
			S_INS_WR: begin
				wr_en = 1'b1;
			end
			S_DOWN: begin
				rd_en   = 1'b1;
				wr_en   = pend_q;
				wr_addr = IDX_W'(prev_q - 1'b1);
				wr_data = rd_data;
			end
			S_DOWN_LAST: begin
				wr_en   = 1'b1;
				wr_addr = IDX_W'(prev_q - 1'b1);
				wr_data = rd_data;
			end
			S_LIST: begin
				out_load  = can_load;
				ld_status = ST_OK;
				ld_key    = rd_key;
				ld_qty    = rd_qty;
				ld_last   = (idx_inc == count_q);
				rd_en     = can_load && !ld_last;
				rd_addr   = idx_inc[IDX_W-1:0];
			end
			S_RESP: begin
				out_load = can_load;
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_EXEC: begin
					pend_q <= 1'b0;
					if (op_q == OP_ERASE && hit_q && (pos_q + 1'b1 == count_q)) begin
						count_q <= count_q - 1'b1;
					end
				end
				S_UP, S_DOWN: pend_q <= 1'b1;
				S_INS_WR:     count_q <= count_q + 1'b1;
				S_DOWN_LAST:  count_q <= count_q - 1'b1;
				default: ;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					op_q         <= operation;
					key_q        <= part_key;
					val_q        <= quantity_value;
					idx_q        <= '0;
					pos_q        <= '0;
					hit_q        <= 1'b0;
					held_q       <= '0;
					res_status_q <= (operation == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
					res_key_q    <= (operation == OP_LIST) ? '0 : part_key;
					res_qty_q    <= '0;
				end
			end
			S_SCAN: begin
				idx_q <= idx_inc;
				if (scan_done) begin
					pos_q  <= scan_ge ? idx_q : count_q;
					hit_q  <= (rd_key == key_q);
					held_q <= rd_qty;
				end
			end
			S_EXEC: begin
				res_key_q    <= key_q;
				res_status_q <= hit_q ? ST_OK : ST_NOT_FOUND;
				res_qty_q    <= hit_q ? held_q : '0;
				case (op_q)
					OP_INSERT: begin
						res_status_q <= hit_q ? ST_PRESENT : ST_OK;
						res_qty_q    <= hit_q ? held_q : val_q;
						idx_q        <= count_q - 1'b1;
					end
					OP_ADJUST: begin
						res_qty_q <= hit_q ? adj_sum : '0;
					end
					OP_ERASE: begin
						idx_q <= pos_q + 1'b1;
					end
					OP_LOOKUP: ;
					default: begin
						res_status_q <= ST_NOT_FOUND;
						res_qty_q    <= '0;
					end
				endcase
			end
			S_UP: begin
				prev_q <= idx_q;
				idx_q  <= idx_q - 1'b1;
			end
			S_DOWN: begin
				prev_q <= idx_q;
				idx_q  <= idx_inc;
			end
			S_LIST: begin
				if (can_load) begin
					idx_q <= idx_inc;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			status_q    <= ld_status;
			entry_key_q <= ld_key;
			entry_qty_q <= ld_qty;
			last_q      <= ld_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign entry_key      = entry_key_q;
	assign entry_quantity = entry_qty_q;
	assign last           = last_q;

	// Checks
	`SKQT_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
	`SKQT_ASSERT_IMPL(a_no_stray_write, clk, arst_n, state_q == S_IDLE || state_q == S_LIST || state_q == S_RESP, !wr_en, "RAM write outside an update")
	`SKQT_ASSERT_NEXT(a_last_ends_item, clk, arst_n, out_load && ld_last, state_q == S_IDLE, "final result loaded without returning to idle")
	`SKQT_ASSERT_NEXT(a_insert_counts, clk, arst_n, state_q == S_INS_WR, count_q == $past(count_q) + 1'b1, "insert did not grow the table")

endmodule
